// ----- rtl/modem_frame_deframer_top_defines.svh -----
// Assertion macros shared by the modem frame deframer RTL.
`ifndef MODEM_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define MODEM_FRAME_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
// Check that an implication holds at every clock edge outside reset.
`define MFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds at any clock edge outside reset.
`define MFD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MFD_ASSERT(lbl, prop, msg)
`define MFD_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/mfd_pkg.sv -----
// Shared constants, types and helpers of the modem frame deframer.
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int unsigned OFS_W   = 17;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned CNT_W   = 3;

  localparam logic [7:0] SYNC_BYTE      = 8'h57;
  localparam logic [7:0] KIND_MONITOR   = 8'h43;
  localparam logic [7:0] KIND_NETWORK   = 8'h44;
  localparam logic [7:0] KIND_PARAM     = 8'h50;
  localparam logic [7:0] MAC_LENGTH_LOW = 8'h12;

  localparam logic [OFS_W-1:0] OFS_KIND      = 17'd1;
  localparam logic [OFS_W-1:0] OFS_LEN_LOW   = 17'd2;
  localparam logic [OFS_W-1:0] OFS_LEN_HIGH  = 17'd3;
  localparam logic [OFS_W-1:0] OFS_NET_FIRST = 17'd6;
  localparam logic [OFS_W-1:0] OFS_MAC_FIRST = 17'd10;
  localparam logic [OFS_W-1:0] OFS_MAC_LAST  = 17'd15;
  localparam logic [OFS_W-1:0] HEADER_BYTES  = 17'd4;
  localparam logic [OFS_W-1:0] TRAILER_BYTES = 17'd2;

  localparam logic [CNT_W-1:0] MIN_BUFFER_SEEN = 3'd3;
  localparam logic [CNT_W-1:0] BYTES_SAT       = 3'd4;

  typedef enum logic [1:0] {
    ROUTE_DROP    = 2'd0,
    ROUTE_MONITOR = 2'd1,
    ROUTE_NETWORK = 2'd2
  } route_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SYNC     = 3'd1,
    ST_UNKNOWN_KIND = 3'd2,
    ST_SHORT_BUFFER = 3'd3,
    ST_TRUNCATED    = 3'd4
  } status_e;

  // One accepted input word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  // One result word
  typedef struct packed {
    status_e          status;
    logic [MAC_W-1:0] mac_addr;
    logic             mac_load;
    logic             sink_last;
    route_e           route;
    logic [7:0]       data;
  } out_word_t;

  function automatic logic kind_known(logic [7:0] kind);
    return (kind == KIND_MONITOR) || (kind == KIND_NETWORK) || (kind == KIND_PARAM);
  endfunction

endpackage

// ----- rtl/mfd_in_reg.sv -----
// Input register stage of the modem frame deframer.
`timescale 1ns / 1ps

module mfd_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  mfd_pkg::in_word_t s_word_i,
  output logic             s_ready_o,
  input  logic             take_i,
  output logic             valid_o,
  output mfd_pkg::in_word_t word_o
);

  logic              valid_q, valid_d;
  mfd_pkg::in_word_t word_q;
  logic              accept;

  // Take a new word when empty or when the held one leaves in the same cycle
  assign s_ready_o = !valid_q || take_i;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until it moves on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= s_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ----- rtl/mfd_parse.sv -----
// Frame tracking state and per-byte routing decision.
`timescale 1ns / 1ps

module mfd_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mfd_pkg::in_word_t  word_i,
  output mfd_pkg::out_word_t res_o
);

  logic [mfd_pkg::OFS_W-1:0] ofs_q, ofs_d;
  logic [mfd_pkg::OFS_W-1:0] total_q, total_d;
  logic [7:0]                kind_q, kind_d;
  logic [7:0]                len_q, len_d;
  logic [mfd_pkg::CNT_W-1:0] bytes_q, bytes_d;
  logic                      disc_q, disc_d;
  logic [mfd_pkg::MAC_W-1:0] mac_q, mac_d;

  logic [7:0]                b;
  logic                      last;
  logic [7:0]                kind_eff;
  logic [7:0]                len_eff;
  logic [mfd_pkg::OFS_W-1:0] total_eff;
  logic [mfd_pkg::OFS_W:0]   ofs_inc;
  logic                      ends;
  mfd_pkg::route_e           route;
  mfd_pkg::status_e          st;
  logic                      flast;
  logic                      mload;
  logic [mfd_pkg::MAC_W-1:0] maddr;

  assign b    = word_i.data;
  assign last = word_i.last;

  // Work out the result and the next state for the current byte
  always_comb begin
    ofs_d     = ofs_q;
    total_d   = total_q;
    kind_d    = kind_q;
    len_d     = len_q;
    bytes_d   = bytes_q;
    disc_d    = disc_q;
    mac_d     = mac_q;
    kind_eff  = kind_q;
    len_eff   = len_q;
    total_eff = total_q;
    ofs_inc   = {1'b0, ofs_q} + {{mfd_pkg::OFS_W{1'b0}}, 1'b1};
    ends      = 1'b0;
    route     = mfd_pkg::ROUTE_DROP;
    st        = mfd_pkg::ST_OK;
    flast     = 1'b0;
    mload     = 1'b0;
    maddr     = '0;

    if (!disc_q) begin
      if (ofs_q == '0) begin
        // Sync position: a bad byte drops the rest of the buffer
        if (b != mfd_pkg::SYNC_BYTE) begin
          st     = mfd_pkg::ST_BAD_SYNC;
          disc_d = 1'b1;
        end else begin
          ofs_d = mfd_pkg::OFS_KIND;
          if (last) begin
            st = mfd_pkg::ST_TRUNCATED;
          end
        end
      end else begin
        // Capture header fields
        if (ofs_q == mfd_pkg::OFS_KIND) begin
          kind_d   = b;
          kind_eff = b;
          if (!mfd_pkg::kind_known(b)) begin
            st = mfd_pkg::ST_UNKNOWN_KIND;
          end
        end else if (ofs_q == mfd_pkg::OFS_LEN_LOW) begin
          len_d   = b;
          len_eff = b;
        end else if (ofs_q == mfd_pkg::OFS_LEN_HIGH) begin
          total_eff = mfd_pkg::HEADER_BYTES
                    + {{(mfd_pkg::OFS_W-8){1'b0}}, len_q}
                    + {{(mfd_pkg::OFS_W-16){1'b0}}, b, 8'h00}
                    + (mfd_pkg::kind_known(kind_q) ? mfd_pkg::TRAILER_BYTES : '0);
          total_d   = total_eff;
        end

        // Select the sink
        if (kind_eff == mfd_pkg::KIND_MONITOR) begin
          route = mfd_pkg::ROUTE_MONITOR;
        end else if (kind_eff == mfd_pkg::KIND_NETWORK && ofs_q >= mfd_pkg::OFS_NET_FIRST) begin
          route = mfd_pkg::ROUTE_NETWORK;
        end

        // Shift in the address bytes of a parameter frame
        if (kind_eff == mfd_pkg::KIND_PARAM && len_eff == mfd_pkg::MAC_LENGTH_LOW &&
            ofs_q >= mfd_pkg::OFS_MAC_FIRST && ofs_q <= mfd_pkg::OFS_MAC_LAST) begin
          mac_d = {mac_q[mfd_pkg::MAC_W-9:0], b};
          if (ofs_q == mfd_pkg::OFS_MAC_LAST) begin
            mload = 1'b1;
            maddr = mac_d;
          end
        end

        // Close the frame or advance within it
        ends = (ofs_q >= mfd_pkg::OFS_LEN_HIGH) && (ofs_inc >= {1'b0, total_eff});
        if (ends) begin
          ofs_d = '0;
          flast = (route != mfd_pkg::ROUTE_DROP);
        end else begin
          ofs_d = ofs_inc[mfd_pkg::OFS_W-1:0];
          if (last) begin
            if (st == mfd_pkg::ST_OK) begin
              st = mfd_pkg::ST_TRUNCATED;
            end
            flast = (route != mfd_pkg::ROUTE_DROP);
          end
        end
      end
    end

    // Buffer end restarts framing; count bytes up to the saturation point
    if (last) begin
      if (bytes_q < mfd_pkg::MIN_BUFFER_SEEN) begin
        st = mfd_pkg::ST_SHORT_BUFFER;
      end
      ofs_d   = '0;
      disc_d  = 1'b0;
      bytes_d = '0;
    end else if (bytes_q < mfd_pkg::BYTES_SAT) begin
      bytes_d = bytes_q + 3'd1;
    end
  end

  // Advance state only when the byte moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q   <= '0;
      total_q <= '0;
      kind_q  <= '0;
      len_q   <= '0;
      bytes_q <= '0;
      disc_q  <= 1'b0;
      mac_q   <= '0;
    end else if (step_i) begin
      ofs_q   <= ofs_d;
      total_q <= total_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      bytes_q <= bytes_d;
      disc_q  <= disc_d;
      mac_q   <= mac_d;
    end
  end

  always_comb begin
    res_o.data      = b;
    res_o.route     = route;
    res_o.sink_last = flast;
    res_o.mac_load  = mload;
    res_o.mac_addr  = maddr;
    res_o.status    = st;
  end

endmodule

// ----- rtl/mfd_out_reg.sv -----
// Result register stage of the modem frame deframer.
`timescale 1ns / 1ps

module mfd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mfd_pkg::out_word_t res_i,
  output logic               can_load_o,
  input  logic               m_ready_i,
  output logic               m_valid_o,
  output mfd_pkg::out_word_t res_o
);

  logic               valid_q, valid_d;
  mfd_pkg::out_word_t res_q;

  // Room for a new word when empty or when the held one leaves now
  assign can_load_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

// ----- rtl/modem_frame_deframer_top.sv -----
// Top level of the modem frame deframer: splits a read buffer into frames and routes bytes.
//
//   channel   dir   tdata                        tuser                          tlast
//   s_axis    in    [7:0] in_byte                -                              buffer_last
//   m_axis    out   [7:0] out_byte,              [1:0] route, [2] mac_load,     sink_frame_last
//                   [55:8] mac_addr              [5:3] status
//
// One word in and one word out per byte; each byte passes through the input register, then the result register.
// The input register, frame state update and result register sustain one word per cycle while m_axis does not stall.
// Reset clears the frame position, byte count, discard flag and both valid flags.
// A stall on m_axis fills the result register, then the input register, then drops s_axis_tready_o.
`timescale 1ns / 1ps
`include "modem_frame_deframer_top_defines.svh"

module modem_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // buffer_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [7:0] out_byte, [55:8] mac_addr
  output logic [5:0]  m_axis_tuser_o,   // [1:0] route, [2] mac_load, [5:3] status
  output logic        m_axis_tlast_o    // sink_frame_last
);

  mfd_pkg::in_word_t  s_word;
  mfd_pkg::in_word_t  in_word;
  mfd_pkg::out_word_t res;
  mfd_pkg::out_word_t out_word;
  logic               in_valid;
  logic               can_load;
  logic               step;

  assign s_word.data = s_axis_tdata_i;
  assign s_word.last = s_axis_tlast_i;

  // Advance a byte when the result register has room
  assign step = in_valid && can_load;

  mfd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_word_i  (s_word),
    .s_ready_o (s_axis_tready_o),
    .take_i    (step),
    .valid_o   (in_valid),
    .word_o    (in_word)
  );

  mfd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_word),
    .res_o  (res)
  );

  mfd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .res_i      (res),
    .can_load_o (can_load),
    .m_ready_i  (m_axis_tready_i),
    .m_valid_o  (m_axis_tvalid_o),
    .res_o      (out_word)
  );

  // Pack the result word onto the output bus
  assign m_axis_tdata_o = {out_word.mac_addr, out_word.data};
  assign m_axis_tuser_o = {out_word.status, out_word.mac_load, out_word.route};
  assign m_axis_tlast_o = out_word.sink_last;

  // Frame end is marked only on bytes that reach a sink
  `MFD_ASSERT(a_last_routed, step && res.sink_last |-> res.route != mfd_pkg::ROUTE_DROP, "frame end on dropped byte")
  // An address is shown only together with its load flag
  `MFD_ASSERT(a_mac_quiet, step && !res.mac_load |-> res.mac_addr == '0, "address without load")
  // An address load never coincides with routing to a sink
  `MFD_NEVER(a_mac_unrouted, step && res.mac_load && res.route != mfd_pkg::ROUTE_DROP, "address load on routed byte")
  // The result register captures a word only when it is free or draining
  `MFD_ASSERT(a_no_overwrite, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result overwritten during stall")

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the modem frame deframer: feeds read buffers and checks every result word.
`timescale 1ns / 1ps

module tb_top;
  import mfd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;    // buffer_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata_o;         // [7:0] out_byte, [55:8] mac_addr
  logic [5:0]  m_axis_tuser_o;         // [1:0] route, [2] mac_load, [5:3] status
  logic        m_axis_tlast_o;         // sink_frame_last

  modem_frame_deframer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Deframer state as the predictor tracks it
  logic [OFS_W-1:0] pos_in_frame = '0;
  logic [OFS_W-1:0] frame_len    = '0;
  logic [7:0]       kind_byte    = '0;
  logic [7:0]       len_low_byte = '0;
  logic [CNT_W-1:0] bytes_seen   = '0;
  logic             drop_rest    = 1'b0;
  logic [MAC_W-1:0] mac_accum    = '0;

  out_word_t   routed_words[$];
  logic [7:0]  read_buffer[$];
  out_word_t   oldest_word;
  int          stall_pct = 16;
  int          error_count = 0;
  int          bytes_sent = 0;
  int          words_seen = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic known_kind(logic [7:0] k);
    return (k == KIND_MONITOR) || (k == KIND_NETWORK) || (k == KIND_PARAM);
  endfunction

  // Advance the deframer state by one byte and return the word it must produce
  function automatic out_word_t deframe_byte(logic [7:0] b, logic last);
    out_word_t        w;
    logic [OFS_W-1:0] off;
    logic             ends;
    w = '0;
    w.data = b;
    w.route = ROUTE_DROP;
    w.status = ST_OK;
    if (!drop_rest) begin
      off = pos_in_frame;
      if (off == '0) begin
        if (b != SYNC_BYTE) begin
          w.status = ST_BAD_SYNC;
          drop_rest = 1'b1;
        end else begin
          pos_in_frame = OFS_KIND;
          if (last) w.status = ST_TRUNCATED;
        end
      end else begin
        if (off == OFS_KIND) begin
          kind_byte = b;
          if (!known_kind(b)) w.status = ST_UNKNOWN_KIND;
        end else if (off == OFS_LEN_LOW) begin
          len_low_byte = b;
        end else if (off == OFS_LEN_HIGH) begin
          frame_len = HEADER_BYTES + {9'd0, len_low_byte} + {1'b0, b, 8'h00} +
                      (known_kind(kind_byte) ? TRAILER_BYTES : '0);
        end
        if (kind_byte == KIND_MONITOR) begin
          w.route = ROUTE_MONITOR;
        end else if (kind_byte == KIND_NETWORK && off >= OFS_NET_FIRST) begin
          w.route = ROUTE_NETWORK;
        end
        // Shift in the address bytes of a parameter frame
        if (kind_byte == KIND_PARAM && len_low_byte == MAC_LENGTH_LOW &&
            off >= OFS_MAC_FIRST && off <= OFS_MAC_LAST) begin
          mac_accum = {mac_accum[MAC_W-9:0], b};
          if (off == OFS_MAC_LAST) begin
            w.mac_load = 1'b1;
            w.mac_addr = mac_accum;
          end
        end
        ends = (off >= OFS_LEN_HIGH) && ({1'b0, off} + 18'd1 >= {1'b0, frame_len});
        if (ends) begin
          pos_in_frame = '0;
          if (w.route != ROUTE_DROP) w.sink_last = 1'b1;
        end else begin
          pos_in_frame = off + 1'b1;
          if (last) begin
            if (w.status == ST_OK) w.status = ST_TRUNCATED;
            if (w.route != ROUTE_DROP) w.sink_last = 1'b1;
          end
        end
      end
    end
    // Close the buffer or count its bytes
    if (last) begin
      if (bytes_seen < MIN_BUFFER_SEEN) w.status = ST_SHORT_BUFFER;
      pos_in_frame = '0;
      drop_rest = 1'b0;
      bytes_seen = '0;
    end else if (bytes_seen < BYTES_SAT) begin
      bytes_seen = bytes_seen + 1'b1;
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t word %0d: %s", $realtime, words_seen, msg);
    error_count++;
  endtask

  task automatic compare_field(string field, logic [47:0] got, logic [47:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
  endtask

  // Hold each word until accepted, idling at random before it
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    routed_words.push_back(deframe_byte(b, last));
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (read_buffer[i]) send_byte(read_buffer[i], i == read_buffer.size() - 1);
  endtask

  // Append one well-formed frame with random content
  task automatic append_frame();
    logic [7:0] k;
    logic [7:0] len;
    int         pick;
    int         body;
    pick = $urandom_range(99);
    if (pick < 35) k = KIND_MONITOR;
    else if (pick < 55) k = KIND_NETWORK;
    else if (pick < 75) k = KIND_PARAM;
    else k = 8'($urandom_range(255));
    if (k == KIND_PARAM && $urandom_range(99) < 70) len = MAC_LENGTH_LOW;
    else len = 8'($urandom_range(12));
    read_buffer.push_back(SYNC_BYTE);
    read_buffer.push_back(k);
    read_buffer.push_back(len);
    read_buffer.push_back(8'h00);
    body = len + (known_kind(k) ? 2 : 0);
    repeat (body) read_buffer.push_back(8'($urandom_range(255)));
  endtask

  // Build one read buffer: mostly whole frames, some cut, broken or too short
  task automatic build_random_buffer();
    int pick;
    int cut;
    read_buffer.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      if ($urandom_range(1)) begin
        read_buffer.push_back(SYNC_BYTE);
        read_buffer.push_back(KIND_MONITOR);
      end
      repeat ($urandom_range(1, 3) - read_buffer.size() + 2)
        read_buffer.push_back(8'($urandom_range(255)));
      while (read_buffer.size() > 3) void'(read_buffer.pop_back());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(99) < 5) read_buffer.push_back(8'($urandom_range(255)));
        append_frame();
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        cut = $urandom_range(1, 8);
        while (cut > 0 && read_buffer.size() > 1) begin
          void'(read_buffer.pop_back());
          cut--;
        end
      end else if (pick < 22) begin
        // Frame far longer than the buffer
        read_buffer.push_back(SYNC_BYTE);
        read_buffer.push_back($urandom_range(1) ? KIND_MONITOR : 8'($urandom_range(255)));
        read_buffer.push_back(8'($urandom_range(255)));
        read_buffer.push_back(8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 10)) read_buffer.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (routed_words.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        oldest_word = routed_words.pop_front();
        compare_field("out_byte", m_axis_tdata_o[7:0], oldest_word.data);
        compare_field("mac_addr", m_axis_tdata_o[55:8], oldest_word.mac_addr);
        compare_field("route", m_axis_tuser_o[1:0], oldest_word.route);
        compare_field("mac_load", m_axis_tuser_o[2], oldest_word.mac_load);
        compare_field("status", m_axis_tuser_o[5:3], oldest_word.status);
        compare_field("sink_frame_last", m_axis_tlast_o, oldest_word.sink_last);
      end
      words_seen++;
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Buffers shorter than four bytes, including a lone sync byte
  task automatic test_short_buffers();
    read_buffer = '{SYNC_BYTE};
    send_buffer();
    read_buffer = '{8'h00, 8'hFF};
    send_buffer();
  endtask

  // Bad sync byte discards the rest of the buffer
  task automatic test_bad_sync();
    read_buffer = '{8'hA8, SYNC_BYTE, KIND_MONITOR, 8'h00};
    send_buffer();
  endtask

  // Unknown, monitor and network frames back to back, then a sync on the last byte
  task automatic test_frame_kinds();
    read_buffer = '{SYNC_BYTE, 8'hFF, 8'h00, 8'h00,
                    SYNC_BYTE, KIND_MONITOR, 8'h00, 8'h00, 8'h01, 8'h02,
                    SYNC_BYTE, KIND_NETWORK, 8'h01, 8'h00, 8'hAA, 8'hBB, 8'h55,
                    SYNC_BYTE};
    send_buffer();
  endtask

  task automatic test_random_buffers(int n_bytes, int pct);
    int target;
    stall_pct = pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_random_buffer();
      send_buffer();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_buffers();
    test_bad_sync();
    test_frame_kinds();
    test_random_buffers(450, 16);
    test_random_buffers(450, 0);
    test_random_buffers(450, 16);
    s_axis_tvalid <= 1'b0;
    while (routed_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
